/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define B64E_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define B64E_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define B64E_ASSERT(label, clk, rst, prop, msg)

`define B64E_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared types, phase codes and the alphabet mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam logic [1:0] PHASE_ZERO = 2'd0;
   localparam logic [1:0] PHASE_ONE  = 2'd1;
   localparam logic [1:0] PHASE_TWO  = 2'd2;

   localparam logic [6:0] PAD_CHAR = 7'd61;

   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            text_end;
   } job_type;

   typedef struct packed {
      logic [1:0] phase;
      logic [3:0] leftover;
   } front_status_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] wide;
      logic [6:0] r;
      wide = {1'b0, v};
      if (v < 6'd26) begin
         r = wide + 7'd65;
      end else if (v < 6'd52) begin
         r = wide + 7'd71;
      end else if (v < 6'd62) begin
         r = wide - 7'd4;
      end else if (v == 6'd62) begin
         r = 7'd43;
      end else begin
         r = 7'd47;
      end
      return r;
   endfunction

endpackage

/* rtl/b64e_req_if.sv */
// ----------------------------------------------------------------------------
// Base64 encoder request channel
// Valid/ready channel carrying one raw byte and its final flag.
// ----------------------------------------------------------------------------
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

/* rtl/b64e_rsp_if.sv */
// ----------------------------------------------------------------------------
// Base64 encoder response channel
// Valid/ready channel carrying one encoded character and its markers.
// ----------------------------------------------------------------------------
interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] text_char;
   logic       run_last;
   logic       text_last;

   modport source (output valid, output text_char, output run_last, output text_last,
                   input ready);
   modport sink   (input valid, input text_char, input run_last, input text_last,
                   output ready);
endinterface

/* rtl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into standard-alphabet Base64 text with padding.
//
//   channel   | dir | payload
//   ----------+-----+-------------------------------------------
//   req_chan  | in  | data_byte[7:0], final_byte
//   rsp_chan  | out | text_char[6:0], run_last, text_last
//
// The emitter sends one character per clock while the response side is ready;
// a request yields one character in phases 0 and 1 and two in phase 2; a final
// request yields four in phase 0, three in phase 1 and two in phase 2. A job is
// written into a queue slot and then loaded into the response register.
// A two-entry job queue lets the front take new requests while the response
// register stalls. Reset is synchronous and clears phase, queue and valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_stream_encoder
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_chan,
   b64e_rsp_if.source rsp_chan
);

   job_type          push_job, head;
   front_status_type fstat;
   logic             push, pop, q_not_empty, q_not_full;
   logic [1:0]       q_count;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_not_full (q_not_full),
      .push       (push),
      .push_job   (push_job),
      .status     (fstat)
   );

   b64e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head      (head),
      .not_empty (q_not_empty),
      .not_full  (q_not_full),
      .count     (q_count)
   );

   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_not_empty (q_not_empty),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

   `B64E_ASSERT(a_text_last_ends_run, clock, reset, rsp_chan.valid && rsp_chan.text_last |-> rsp_chan.run_last, "text_last without run_last")
   `B64E_ASSERT(a_final_resets_phase, clock, reset, push && req_chan.final_byte |=> fstat.phase == PHASE_ZERO && fstat.leftover == 4'd0, "state not cleared after final request")
   `B64E_ASSERT(a_push_fills_queue, clock, reset, push |=> q_count != 2'd0, "pushed job missing from queue")
   `B64E_ASSERT_NEVER(a_queue_bound, clock, reset, q_count == 2'd3, "queue count overflow")

endmodule

/* rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts requests, tracks group phase and builds the character job.
// ----------------------------------------------------------------------------
module b64e_front
   import b64e_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   b64e_req_if.sink         req,
   input  logic             q_not_full,
   output logic             push,
   output job_type          push_job,
   output front_status_type status
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic [7:0] b;

   assign b         = req.data_byte;
   assign req.ready = q_not_full;
   assign push      = req.valid && q_not_full;
   assign status    = '{phase: phase_ff, leftover: left_ff};

   always_comb begin
      push_job.chars    = {4{PAD_CHAR}};
      push_job.last_idx = 2'd0;
      push_job.text_end = req.final_byte;
      phase_in          = phase_ff;
      left_in           = left_ff;
      unique case (phase_ff)
         PHASE_ONE: begin
            push_job.chars[0] = sextet_char({left_ff[1:0], b[7:4]});
            if (req.final_byte) begin
               push_job.chars[1] = sextet_char({b[3:0], 2'b00});
               push_job.last_idx = 2'd2;
            end
            left_in  = b[3:0];
            phase_in = PHASE_TWO;
         end
         PHASE_TWO: begin
            push_job.chars[0] = sextet_char({left_ff, b[7:6]});
            push_job.chars[1] = sextet_char(b[5:0]);
            push_job.last_idx = 2'd1;
            left_in  = 4'd0;
            phase_in = PHASE_ZERO;
         end
         default: begin
            push_job.chars[0] = sextet_char(b[7:2]);
            if (req.final_byte) begin
               push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
               push_job.last_idx = 2'd3;
            end
            left_in  = {2'b00, b[1:0]};
            phase_in = PHASE_ONE;
         end
      endcase
      if (req.final_byte) begin
         left_in  = 4'd0;
         phase_in = PHASE_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_ZERO;
         left_ff  <= 4'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

/* rtl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Two-entry queue between front end and character emitter.
// ----------------------------------------------------------------------------
module b64e_queue
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    push_job,
   input  logic       pop,
   output job_type    head,
   output logic       not_empty,
   output logic       not_full,
   output logic [1:0] count
);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = count_ff != 2'd0;
   assign not_full  = count_ff != 2'd2;
   assign count     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// Base64 encoder character emitter
// Walks the head job one character per cycle into the response register while that register is empty or taken.
// ----------------------------------------------------------------------------
module b64e_back
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head,
   input  logic       q_not_empty,
   output logic       pop,
   b64e_rsp_if.source rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [6:0] char_ff;
   logic       run_ff, tlast_ff;
   logic       load, at_end;

   assign load   = q_not_empty && (!vld_ff || rsp.ready);
   assign at_end = idx_ff == head.last_idx;
   assign pop    = load && at_end;

   assign rsp.valid     = vld_ff;
   assign rsp.text_char = char_ff;
   assign rsp.run_last  = run_ff;
   assign rsp.text_last = tlast_ff;

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (!vld_ff || rsp.ready) begin
         vld_in = q_not_empty;
      end
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   // advance payload on each loaded character
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff  <= head.chars[idx_ff];
         run_ff   <= at_end;
         tlast_ff <= at_end && head.text_end;
      end
   end

endmodule

/* verif/base64_stream_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Sends whole messages of raw bytes, each closed by a final byte. A table of
// directed requests comes first; typed expectations cover the padded and
// saturated cases. Random messages follow under several idle and stall
// mixes, with one long response hold-off. Each received character is
// compared with its typed expectation or with an independent encoder model.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;
   import b64e_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 80;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_REQUESTS = 42;
   localparam int PRINT_CAP      = 30;

   localparam bit [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [6:0] text_char;
      logic       run_last;
      logic       text_last;
   } text_rec_type;

   typedef struct {
      logic [7:0]  data;
      logic        fin;
      int unsigned n_typed;
      logic [31:0] typed;
   } dir_row_type;

   dir_row_type directed_rows [0:23] = '{
      '{8'h00, 1'b1, 4, "AA=="},
      '{8'hFF, 1'b1, 4, "/w=="},
      '{8'hFF, 1'b0, 1, "/"},
      '{8'hFF, 1'b1, 3, "/8="},
      '{8'hFF, 1'b0, 1, "/"},
      '{8'hFF, 1'b0, 1, "/"},
      '{8'hFF, 1'b1, 2, "//"},
      '{8'h00, 1'b0, 1, "A"},
      '{8'h00, 1'b0, 1, "A"},
      '{8'h00, 1'b1, 2, "AA"},
      '{8'h4D, 1'b0, 1, "T"},
      '{8'h61, 1'b0, 1, "W"},
      '{8'h6E, 1'b1, 2, "Fu"},
      '{8'hAA, 1'b0, 0, 0},
      '{8'h55, 1'b1, 0, 0},
      '{8'h0F, 1'b0, 0, 0},
      '{8'hF0, 1'b0, 0, 0},
      '{8'h3C, 1'b0, 0, 0},
      '{8'hC3, 1'b1, 0, 0},
      '{8'h01, 1'b1, 0, 0},
      '{8'h80, 1'b0, 0, 0},
      '{8'h7F, 1'b0, 0, 0},
      '{8'hFE, 1'b0, 0, 0},
      '{8'h01, 1'b1, 0, 0}
   };

   logic clock;
   logic reset;

   b64e_req_if req_if ();
   b64e_rsp_if rsp_if ();

   base64_stream_encoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   text_rec_type expected_chars [$];
   logic [3:0]   carry_bits;
   logic [1:0]   group_pos;
   int unsigned  idle_pct;
   int unsigned  stall_pct;
   int unsigned  mismatch_cnt;
   int unsigned  request_cnt;
   int unsigned  char_cnt;
   int unsigned  message_cnt;
   int unsigned  quiet_cycles;
   bit           hold_start;
   bit           hold_off;

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   function automatic logic [6:0] to_char(input logic [5:0] v);
      return B64_ALPHABET[v][6:0];
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_cnt < PRINT_CAP) begin
         $display("[%0t] MISMATCH %s: got %0d want %0d", $time, what, got, want);
      end
      mismatch_cnt++;
   endtask

   task automatic add_expected(input logic [6:0] c, input logic rl, input logic tl);
      text_rec_type rec;
      rec.text_char = c;
      rec.run_last  = rl;
      rec.text_last = tl;
      expected_chars.insert(expected_chars.size(), rec);
   endtask

   // advance the encoder model by one request
   task automatic encode_byte(input logic [7:0] b, input logic fin, input bit push);
      logic [6:0] chars [4];
      int n;
      n = 0;
      case (group_pos)
         PHASE_ONE: begin
            chars[0]   = to_char({carry_bits[1:0], b[7:4]});
            n          = 1;
            carry_bits = b[3:0];
            group_pos  = PHASE_TWO;
            if (fin) begin
               chars[1] = to_char({b[3:0], 2'b00});
               chars[2] = PAD_CHAR;
               n        = 3;
            end
         end
         PHASE_TWO: begin
            chars[0]   = to_char({carry_bits, b[7:6]});
            chars[1]   = to_char(b[5:0]);
            n          = 2;
            carry_bits = 4'd0;
            group_pos  = PHASE_ZERO;
         end
         default: begin
            chars[0]   = to_char(b[7:2]);
            n          = 1;
            carry_bits = {2'b00, b[1:0]};
            group_pos  = PHASE_ONE;
            if (fin) begin
               chars[1] = to_char({b[1:0], 4'b0000});
               chars[2] = PAD_CHAR;
               chars[3] = PAD_CHAR;
               n        = 4;
            end
         end
      endcase
      if (fin) begin
         carry_bits = 4'd0;
         group_pos  = PHASE_ZERO;
      end
      if (push) begin
         for (int k = 0; k < n; k++) begin
            add_expected(chars[k], (k == n - 1), (fin && k == n - 1));
         end
      end
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic fin, input bit push);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= b;
      req_if.final_byte <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      encode_byte(b, fin, push);
      request_cnt++;
      if (fin) message_cnt++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int unsigned len);
      logic [7:0] b;
      for (int unsigned i = 0; i < len; i++) begin
         case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
         endcase
         offer_byte(b, (i == len - 1), 1'b1);
      end
   endtask

   task automatic run_random_phase(input int unsigned idle, input int unsigned stall);
      int unsigned start;
      idle_pct  = idle;
      stall_pct = stall;
      start     = request_cnt;
      while (request_cnt - start < PHASE_REQUESTS) begin
         if ($urandom_range(9) == 0) send_message($urandom_range(10, 20));
         else                        send_message($urandom_range(1, 9));
      end
      drain();
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   initial begin : long_hold
      hold_off = 1'b0;
      wait (hold_start);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      text_rec_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         char_cnt++;
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", rsp_if.text_char, -1);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_if.text_char !== want.text_char)
               report_mismatch("text_char", rsp_if.text_char, want.text_char);
            if (rsp_if.run_last !== want.run_last)
               report_mismatch("run_last", rsp_if.run_last, want.run_last);
            if (rsp_if.text_last !== want.text_last)
               report_mismatch("text_last", rsp_if.text_last, want.text_last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : main
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.data_byte  = 8'h00;
      req_if.final_byte = 1'b0;
      rsp_if.ready      = 1'b0;
      carry_bits        = 4'd0;
      group_pos         = PHASE_ZERO;
      idle_pct          = 0;
      stall_pct         = 0;
      mismatch_cnt      = 0;
      request_cnt       = 0;
      char_cnt          = 0;
      message_cnt       = 0;
      quiet_cycles      = 0;
      hold_start        = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].n_typed == 0);
         for (int unsigned k = 0; k < directed_rows[i].n_typed; k++) begin
            add_expected(
               directed_rows[i].typed[8 * (directed_rows[i].n_typed - 1 - k) +: 7],
               (k == directed_rows[i].n_typed - 1),
               (directed_rows[i].fin && k == directed_rows[i].n_typed - 1));
         end
      end
      drain();

      // hold the response side while requests keep coming
      idle_pct   = 0;
      stall_pct  = 0;
      hold_start = 1'b1;
      send_message(24);
      drain();

      run_random_phase(0, 0);
      run_random_phase(68, 0);
      run_random_phase(0, 68);
      run_random_phase(11, 11);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests in %0d messages, %0d characters checked",
               request_cnt, message_cnt, char_cnt);
      $display("phases: directed, long response hold-off, idle/stall mixes 0/0 68/0 0/68 11/11");
      if (mismatch_cnt == 0 && expected_chars.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
